@@ rtl/core/pmd_pkg.sv @@
// constants and types shared by the peak min/max detector modules
package pmd_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W = 32;
   localparam int BLOCK_SIZE_W = 16;
   localparam int CHAN_COUNT_W = 4;
   localparam int SAMPLE_BYTES_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CHANNEL_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_BYTES = 2'd2;

   localparam logic [SAMPLE_BYTES_W-1:0] SB_BYTE = 2'd1;

   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd256;
   localparam logic [CHAN_COUNT_W-1:0] CHAN_COUNT_RESET = 4'd2;
   localparam logic [SAMPLE_BYTES_W-1:0] SAMPLE_BYTES_RESET = 2'd2;

   typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] lane_array_type;

   typedef struct packed {
      lane_array_type peak_high;
      lane_array_type peak_low;
      logic [NCH_W-1:0] nch;
      logic [COUNT_W-1:0] frame;
      logic [COUNT_W-1:0] blocks;
   } block_entry_type;

endpackage

@@ rtl/core/pmd_front.sv @@
// front end: config registers, sample centring and per-channel block statistics
module pmd_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [pmd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [pmd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic push_valid,
   input  logic push_ready,
   output pmd_pkg::block_entry_type push_data
);
   import pmd_pkg::*;

   logic [BLOCK_SIZE_W-1:0] block_size_ff;
   logic [CHAN_COUNT_W-1:0] channel_count_ff;
   logic [SAMPLE_BYTES_W-1:0] sample_bytes_ff;

   lane_array_type chan_max_ff, chan_max_in;
   lane_array_type chan_min_ff, chan_min_in;
   logic [CH_W-1:0] chan_index_ff, chan_index_in;
   logic [BLOCK_SIZE_W-1:0] frame_in_block_ff, frame_in_block_in;
   logic [COUNT_W-1:0] frame_total_ff, frame_total_in;
   logic [SAMPLE_W:0] largest_mag_ff, largest_mag_in;
   logic [COUNT_W-1:0] largest_pos_ff, largest_pos_in;
   logic [COUNT_W-1:0] blocks_done_ff, blocks_done_in;

   logic accept;
   logic [SAMPLE_W-1:0] centred;
   logic [SAMPLE_W:0] mag;
   logic [NCH_W-1:0] nch_eff;
   logic [BLOCK_SIZE_W-1:0] bs_eff;
   logic frame_end;
   logic block_end;

   assign csr_ready = 1'b1;
   assign req_stall = !push_ready;
   assign accept = req_valid && push_ready;

   always_comb begin
      if (sample_bytes_ff == SB_BYTE) begin
         centred = {{8{~req_sample[7]}}, ~req_sample[7], req_sample[6:0]};
      end else begin
         centred = req_sample;
      end
      mag = centred[SAMPLE_W-1] ? ({1'b0, ~centred} + (SAMPLE_W+1)'(1)) : {1'b0, centred};

      if (channel_count_ff == '0) begin
         nch_eff = NCH_W'(1);
      end else if (32'(channel_count_ff) > 32'(MAX_CHANNELS)) begin
         nch_eff = NCH_W'(MAX_CHANNELS);
      end else begin
         nch_eff = NCH_W'(channel_count_ff);
      end
      bs_eff = (block_size_ff == '0) ? BLOCK_SIZE_W'(1) : block_size_ff;

      frame_end = (NCH_W'(chan_index_ff) + NCH_W'(1)) >= nch_eff;
      block_end = ({1'b0, frame_in_block_ff} + (BLOCK_SIZE_W+1)'(1)) >= {1'b0, bs_eff};
   end

   always_comb begin
      chan_max_in = chan_max_ff;
      chan_min_in = chan_min_ff;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (accept && chan_index_ff == CH_W'(i)) begin
            if (frame_in_block_ff == '0) begin
               chan_max_in[i] = centred;
               chan_min_in[i] = centred;
            end else begin
               if ($signed(centred) > $signed(chan_max_ff[i])) chan_max_in[i] = centred;
               if ($signed(centred) < $signed(chan_min_ff[i])) chan_min_in[i] = centred;
            end
         end
      end

      chan_index_in = chan_index_ff;
      frame_in_block_in = frame_in_block_ff;
      frame_total_in = frame_total_ff;
      largest_mag_in = largest_mag_ff;
      largest_pos_in = largest_pos_ff;
      blocks_done_in = blocks_done_ff;

      if (accept) begin
         if (mag > largest_mag_ff) begin
            largest_mag_in = mag;
            largest_pos_in = frame_total_ff;
         end
         if (!frame_end) begin
            chan_index_in = chan_index_ff + CH_W'(1);
         end else begin
            chan_index_in = '0;
            frame_total_in = frame_total_ff + COUNT_W'(1);
            if (!block_end) begin
               frame_in_block_in = frame_in_block_ff + BLOCK_SIZE_W'(1);
            end else begin
               frame_in_block_in = '0;
               blocks_done_in = blocks_done_ff + COUNT_W'(1);
            end
         end
      end
   end

   assign push_valid = accept && frame_end && block_end;
   assign push_data.peak_high = chan_max_in;
   assign push_data.peak_low = chan_min_in;
   assign push_data.nch = nch_eff;
   assign push_data.frame = largest_pos_in;
   assign push_data.blocks = blocks_done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RESET;
         channel_count_ff <= CHAN_COUNT_RESET;
         sample_bytes_ff <= SAMPLE_BYTES_RESET;
         chan_max_ff <= '0;
         chan_min_ff <= '0;
         chan_index_ff <= '0;
         frame_in_block_ff <= '0;
         frame_total_ff <= '0;
         largest_mag_ff <= '0;
         largest_pos_ff <= '0;
         blocks_done_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_BLOCK_SIZE: block_size_ff <= csr_wdata[BLOCK_SIZE_W-1:0];
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHAN_COUNT_W-1:0];
               CSR_SAMPLE_BYTES: sample_bytes_ff <= csr_wdata[SAMPLE_BYTES_W-1:0];
               default: ;
            endcase
         end
         chan_max_ff <= chan_max_in;
         chan_min_ff <= chan_min_in;
         chan_index_ff <= chan_index_in;
         frame_in_block_ff <= frame_in_block_in;
         frame_total_ff <= frame_total_in;
         largest_mag_ff <= largest_mag_in;
         largest_pos_ff <= largest_pos_in;
         blocks_done_ff <= blocks_done_in;
      end
   end

endmodule

@@ rtl/core/pmd_queue.sv @@
// two-entry queue of finished block snapshots between front and back
module pmd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  pmd_pkg::block_entry_type push_data,
   output logic pop_valid,
   input  logic pop,
   output pmd_pkg::block_entry_type pop_data
);
   import pmd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   block_entry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/pmd_back.sv @@
// back end: drains one block snapshot as one result per channel
module pmd_back (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop,
   input  pmd_pkg::block_entry_type pop_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [pmd_pkg::CHANNEL_W-1:0] rsp_channel,
   output logic [pmd_pkg::SAMPLE_W-1:0] rsp_peak_high,
   output logic [pmd_pkg::SAMPLE_W-1:0] rsp_peak_low,
   output logic rsp_last,
   output logic [pmd_pkg::COUNT_W-1:0] rsp_peak_of_peaks_frame,
   output logic [pmd_pkg::COUNT_W-1:0] rsp_block_count
);
   import pmd_pkg::*;

   logic busy_ff, busy_in;
   logic [CH_W-1:0] k_ff, k_in;
   lane_array_type high_ff, high_in;
   lane_array_type low_ff, low_in;
   logic [NCH_W-1:0] nch_ff, nch_in;
   logic [COUNT_W-1:0] frame_ff, frame_in;
   logic [COUNT_W-1:0] blocks_ff, blocks_in;
   logic taken;
   logic is_last;

   assign is_last = (NCH_W'(k_ff) + NCH_W'(1)) == nch_ff;
   assign taken = busy_ff && !rsp_stall;
   assign pop = pop_valid && (!busy_ff || (taken && is_last));

   always_comb begin
      busy_in = busy_ff;
      k_in = k_ff;
      high_in = high_ff;
      low_in = low_ff;
      nch_in = nch_ff;
      frame_in = frame_ff;
      blocks_in = blocks_ff;
      if (pop) begin
         busy_in = 1'b1;
         k_in = '0;
         high_in = pop_data.peak_high;
         low_in = pop_data.peak_low;
         nch_in = pop_data.nch;
         frame_in = pop_data.frame;
         blocks_in = pop_data.blocks;
      end else if (taken) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + CH_W'(1);
            for (int i = 0; i < MAX_CHANNELS - 1; i++) begin
               high_in[i] = high_ff[i+1];
               low_in[i] = low_ff[i+1];
            end
         end
      end
   end

   assign rsp_valid = busy_ff;
   assign rsp_channel = CHANNEL_W'(k_ff);
   assign rsp_peak_high = high_ff[0];
   assign rsp_peak_low = low_ff[0];
   assign rsp_last = is_last;
   assign rsp_peak_of_peaks_frame = frame_ff;
   assign rsp_block_count = blocks_ff;

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff <= low_in;
      nch_ff <= nch_in;
      frame_ff <= frame_in;
      blocks_ff <= blocks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff <= k_in;
      end
   end

endmodule

@@ rtl/core/block_peak_min_max_detector.sv @@
// top level of the block peak min/max detector
//
//   channel  direction  handshake          payload
//   req_     in         valid / stall      sample
//   rsp_     out        valid / stall      channel, peak pair, last, frame, block count
//   csr_     in         valid / ready      index, write data
//
// one request is taken per cycle while req_stall is low; the statistics update completes in that cycle.
// at a block end the channel snapshot enters a two-entry queue; the back end
// sends one result per cycle while rsp_stall is low, one result per channel of the block.
// req_stall rises only while the queue is full; rsp_stall holds the current result.
// synchronous active-high reset restores the default registers and clears all counts.
module block_peak_min_max_detector (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [pmd_pkg::SAMPLE_W-1:0] req_sample,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [pmd_pkg::CHANNEL_W-1:0] rsp_channel,
   output logic signed [pmd_pkg::SAMPLE_W-1:0] rsp_peak_high,
   output logic signed [pmd_pkg::SAMPLE_W-1:0] rsp_peak_low,
   output logic rsp_last,
   output logic [pmd_pkg::COUNT_W-1:0] rsp_peak_of_peaks_frame,
   output logic [pmd_pkg::COUNT_W-1:0] rsp_block_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [pmd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pmd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pmd_pkg::*;

   logic push_valid;
   logic push_ready;
   block_entry_type push_data;
   logic pop_valid;
   logic pop;
   block_entry_type pop_data;
   logic [SAMPLE_W-1:0] peak_high;
   logic [SAMPLE_W-1:0] peak_low;

   pmd_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data)
   );

   pmd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop(pop),
      .pop_data(pop_data)
   );

   pmd_back u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop(pop),
      .pop_data(pop_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_channel(rsp_channel),
      .rsp_peak_high(peak_high),
      .rsp_peak_low(peak_low),
      .rsp_last(rsp_last),
      .rsp_peak_of_peaks_frame(rsp_peak_of_peaks_frame),
      .rsp_block_count(rsp_block_count)
   );

   assign rsp_peak_high = $signed(peak_high);
   assign rsp_peak_low = $signed(peak_low);

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> req_stall)
      else $error("queue full without input stall");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_channel_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_channel == $past(rsp_channel) + CHANNEL_W'(1))
      else $error("channel sequence broken within block");

   a_block_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_block_count == $past(rsp_block_count)
         && rsp_peak_of_peaks_frame == $past(rsp_peak_of_peaks_frame))
      else $error("block fields changed within block");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the block peak min/max detector
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pmd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS = 38;
   localparam int NUM_PHASES = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0] high;
      logic [SAMPLE_W-1:0] low;
      logic last;
      logic [COUNT_W-1:0] frame;
      logic [COUNT_W-1:0] blocks;
   } peak_result_type;

   typedef struct {
      bit is_csr;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0] value;
      bit typed;
      logic signed [SAMPLE_W-1:0] peak;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CHANNEL_W-1:0] rsp_channel;
   logic signed [SAMPLE_W-1:0] rsp_peak_high;
   logic signed [SAMPLE_W-1:0] rsp_peak_low;
   logic rsp_last;
   logic [COUNT_W-1:0] rsp_peak_of_peaks_frame;
   logic [COUNT_W-1:0] rsp_block_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [BLOCK_SIZE_W-1:0] cfg_block_size = BLOCK_SIZE_RESET;
   logic [CHAN_COUNT_W-1:0] cfg_channels = CHAN_COUNT_RESET;
   logic [SAMPLE_BYTES_W-1:0] cfg_width = SAMPLE_BYTES_RESET;
   logic signed [SAMPLE_W-1:0] run_max [MAX_CHANNELS];
   logic signed [SAMPLE_W-1:0] run_min [MAX_CHANNELS];
   int next_chan = 0;
   int frame_pos = 0;
   int peak_mag = 0;
   logic [COUNT_W-1:0] frames_seen = '0;
   logic [COUNT_W-1:0] peak_frame = '0;
   logic [COUNT_W-1:0] blocks_seen = '0;

   peak_result_type peaks_due [$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   block_peak_min_max_detector i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_channel(rsp_channel),
      .rsp_peak_high(rsp_peak_high),
      .rsp_peak_low(rsp_peak_low),
      .rsp_last(rsp_last),
      .rsp_peak_of_peaks_frame(rsp_peak_of_peaks_frame),
      .rsp_block_count(rsp_block_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s expected %h got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      peak_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (peaks_due.size() == 0) begin
            errors++;
            $display("%0t unexpected result expected none got channel %0d", $time, rsp_channel);
         end else begin
            want = peaks_due.pop_front();
            check_field("channel", want.channel, rsp_channel);
            check_field("peak_high", want.high, $unsigned(rsp_peak_high));
            check_field("peak_low", want.low, $unsigned(rsp_peak_low));
            check_field("last", want.last, rsp_last);
            check_field("peak_frame", want.frame, rsp_peak_of_peaks_frame);
            check_field("block_count", want.blocks, rsp_block_count);
         end
      end
   end

   // block statistics for one accepted request
   task automatic accept_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
                                input logic signed [SAMPLE_W-1:0] typed_peak);
      int nch;
      int bs;
      int centred;
      int mag;
      peak_result_type res;
      nch = (cfg_channels == 0) ? 1 :
            ((cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_channels));
      bs = (cfg_block_size == 0) ? 1 : int'(cfg_block_size);
      centred = (cfg_width == SB_BYTE) ? int'(raw[7:0]) - 128 : int'($signed(raw));
      mag = (centred < 0) ? -centred : centred;
      if (frame_pos == 0) begin
         run_max[next_chan] = SAMPLE_W'(centred);
         run_min[next_chan] = SAMPLE_W'(centred);
      end else begin
         if (centred > run_max[next_chan]) run_max[next_chan] = SAMPLE_W'(centred);
         if (centred < run_min[next_chan]) run_min[next_chan] = SAMPLE_W'(centred);
      end
      if (mag > peak_mag) begin
         peak_mag = mag;
         peak_frame = frames_seen;
      end
      if (next_chan + 1 < nch) begin
         next_chan++;
      end else begin
         next_chan = 0;
         frames_seen++;
         if (frame_pos + 1 < bs) begin
            frame_pos++;
         end else begin
            frame_pos = 0;
            blocks_seen++;
            for (int k = 0; k < nch; k++) begin
               res.channel = CHANNEL_W'(k);
               res.high = typed ? typed_peak : run_max[k];
               res.low = typed ? typed_peak : run_min[k];
               res.last = (k + 1 == nch);
               res.frame = peak_frame;
               res.blocks = blocks_seen;
               peaks_due = {peaks_due, res};
            end
         end
      end
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
                              input logic signed [SAMPLE_W-1:0] typed_peak);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= raw;
      do @(posedge clock); while (req_stall);
      accept_sample(raw, typed, typed_peak);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (peaks_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_BLOCK_SIZE: cfg_block_size = value;
         CSR_CHANNEL_COUNT: cfg_channels = value[CHAN_COUNT_W-1:0];
         CSR_SAMPLE_BYTES: cfg_width = value[SAMPLE_BYTES_W-1:0];
         default: ;
      endcase
   endtask

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] value);
      return '{1'b1, index, value, 1'b0, '0};
   endfunction

   function automatic stim_row_type sample_row(input logic [SAMPLE_W-1:0] raw, input bit typed,
                                               input logic signed [SAMPLE_W-1:0] peak);
      return '{1'b0, CSR_UNUSED, raw, typed, peak};
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] corners [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
                                           16'h0080, 16'h00FF};
      case ($urandom_range(7))
         0: return corners[$urandom_range(5)];
         1: return SAMPLE_W'($urandom_range(16) - 8);
         default: return SAMPLE_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   initial begin
      stim_row_type rows [$];
      static int phase_bs [NUM_PHASES] = '{1, 2, 3, 0, 4, 65535, 5, 2};
      static int phase_ch [NUM_PHASES] = '{1, 8, 3, 0, 12, 2, 5, 8};
      static int phase_sb [NUM_PHASES] = '{1, 2, 0, 3, 1, 2, 1, 2};
      static int phase_idle [4] = '{0, 56, 0, 31};
      static int phase_stall [4] = '{0, 0, 56, 31};

      for (int k = 0; k < MAX_CHANNELS; k++) begin
         run_max[k] = '0;
         run_min[k] = '0;
      end
      rows = '{
         csr_row(CSR_BLOCK_SIZE, 16'd1),
         csr_row(CSR_CHANNEL_COUNT, 16'd1),
         csr_row(CSR_SAMPLE_BYTES, 16'd1),
         sample_row(16'h00FF, 1'b1, 16'sd127),
         sample_row(16'h0000, 1'b1, -16'sd128),
         sample_row(16'hFF80, 1'b1, 16'sd0),
         sample_row(16'h0081, 1'b1, 16'sd1),
         csr_row(CSR_SAMPLE_BYTES, 16'd2),
         sample_row(16'h0005, 1'b1, 16'sd5),
         sample_row(16'h7FFF, 1'b1, 16'sd32767),
         sample_row(16'h8001, 1'b1, -16'sd32767),
         sample_row(16'h8000, 1'b1, -16'sd32768),
         sample_row(16'hFFFF, 1'b1, -16'sd1),
         // odd sample widths behave as 16-bit
         csr_row(CSR_SAMPLE_BYTES, 16'd3),
         sample_row(16'h8001, 1'b1, -16'sd32767),
         csr_row(CSR_SAMPLE_BYTES, 16'd0),
         sample_row(16'h1234, 1'b1, 16'sd4660),
         // zero block size and zero channel count behave as one
         csr_row(CSR_BLOCK_SIZE, 16'd0),
         csr_row(CSR_CHANNEL_COUNT, 16'd0),
         sample_row(16'hFFFE, 1'b1, -16'sd2),
         // channel count above the maximum is clamped
         csr_row(CSR_CHANNEL_COUNT, 16'hFFFF),
         sample_row(16'h0101, 1'b0, '0),
         sample_row(16'h7FFE, 1'b0, '0),
         sample_row(16'h8002, 1'b0, '0),
         sample_row(16'h0000, 1'b0, '0),
         sample_row(16'h5555, 1'b0, '0),
         sample_row(16'hAAAA, 1'b0, '0),
         sample_row(16'h0042, 1'b0, '0),
         sample_row(16'hF00D, 1'b0, '0),
         // channel count grown mid-block leaves a channel unseeded
         csr_row(CSR_CHANNEL_COUNT, 16'd2),
         csr_row(CSR_BLOCK_SIZE, 16'd2),
         sample_row(16'h0010, 1'b0, '0),
         sample_row(16'hFFF0, 1'b0, '0),
         csr_row(CSR_CHANNEL_COUNT, 16'd3),
         sample_row(16'h0020, 1'b0, '0),
         sample_row(16'hFFE0, 1'b0, '0),
         sample_row(16'h0030, 1'b0, '0),
         csr_row(CSR_UNUSED, 16'hABCD)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_csr) write_csr(rows[i].index, rows[i].value);
         else send_sample(rows[i].value, rows[i].typed, rows[i].peak);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_BLOCK_SIZE, CSR_DATA_W'(phase_bs[p]));
         write_csr(CSR_CHANNEL_COUNT, {12'($urandom_range(12'hFFF)), 4'(phase_ch[p])});
         write_csr(CSR_SAMPLE_BYTES, {14'($urandom_range(14'h3FFF)), 2'(phase_sb[p])});
         write_csr(CSR_UNUSED, CSR_DATA_W'($urandom_range(16'hFFFF)));
         send_idle_pct = phase_idle[p % 4];
         stall_pct = phase_stall[p % 4];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // now and then the sender holds off until every block result is out
            if ($urandom_range(29) == 0) drain();
            send_sample(pick_sample(), 1'b0, '0);
         end
      end

      drain();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
